FILE: rtl/pic_pkg.sv
// Shared types and constants for the prioritized interrupt controller.
package pic_pkg;

  localparam int NumSources  = 96;
  localparam int BitsPerBank = 32;
  localparam int NumBanks    = 3;
  localparam int SrcW        = 7;

  localparam logic [5:0]  PrioMask     = 6'h3F;
  localparam logic [7:0]  NoPrio       = 8'hFF;
  localparam logic [31:0] SpuriousCode = 32'hFFFF_FF80;

  // top-level register offsets
  localparam logic [9:0] RegRevision   = 10'h000;
  localparam logic [9:0] RegSysConfig  = 10'h010;
  localparam logic [9:0] RegStatus     = 10'h014;
  localparam logic [9:0] RegIrqSource  = 10'h040;
  localparam logic [9:0] RegFiqSource  = 10'h044;
  localparam logic [9:0] RegControl    = 10'h048;
  localparam logic [9:0] RegProtection = 10'h04C;
  localparam logic [9:0] RegIdle       = 10'h050;
  localparam logic [9:0] RegIrqPrio    = 10'h060;
  localparam logic [9:0] RegFiqPrio    = 10'h064;
  localparam logic [9:0] RegThreshold  = 10'h068;

  // bank and priority word areas
  localparam logic [9:0] BankBase   = 10'h080;
  localparam logic [9:0] BankStride = 10'h020;
  localparam logic [9:0] PrioBase   = 10'h100;

  // register slots within one bank
  localparam logic [4:0] SlotRaw     = 5'h00;
  localparam logic [4:0] SlotMask    = 5'h04;
  localparam logic [4:0] SlotMaskClr = 5'h08;
  localparam logic [4:0] SlotMaskSet = 5'h0C;
  localparam logic [4:0] SlotSoftSet = 5'h10;
  localparam logic [4:0] SlotSoftClr = 5'h14;
  localparam logic [4:0] SlotPendIrq = 5'h18;
  localparam logic [4:0] SlotPendFiq = 5'h1C;

  typedef enum logic [1:0] {
    ActRead  = 2'd0,
    ActWrite = 2'd1,
    ActRaise = 2'd2,
    ActDrop  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ErrOk       = 2'd0,
    ErrUnmapped = 2'd1,
    ErrRange    = 2'd2,
    ErrFiq      = 2'd3
  } error_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  address;
    logic [31:0] write_data;
    logic [6:0]  source;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_request;
    logic [1:0]  error;
  } out_item_t;

endpackage

FILE: rtl/prioritized_interrupt_controller.sv
// Top level of the prioritized interrupt controller.
// Each transaction is executed, then a sequential scan reads the priority word of
// every source from the memory (address, then registered word) before the result.
// Transactions are processed one at a time and output stalls hold the result; the queue buffers two.
// Reset (async, active low): lines and soft bits clear, all sources masked,
// threshold 255. Priority words read as zero until written.
module prioritized_interrupt_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pic_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pic_pkg::out_item_t out_data_o
);
  import pic_pkg::*;

  logic     q_push, q_pop, q_full, q_empty;
  in_item_t q_in, q_out;

  pic_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .q_full_i(q_full), .q_push_o(q_push), .q_data_o(q_in)
  );

  pic_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(q_push), .data_i(q_in), .full_o(q_full),
    .pop_i(q_pop), .empty_o(q_empty), .data_o(q_out)
  );

  pic_back u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .q_data_i(q_out), .q_pop_o(q_pop),
    .out_valid_o, .out_stall_i, .out_data_o
  );
endmodule

FILE: rtl/pic_fifo.sv
// Two-entry queue between the front and back parts.
module pic_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pic_pkg::in_item_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output pic_pkg::in_item_t data_o
);
  import pic_pkg::*;

  in_item_t   mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end
endmodule

FILE: rtl/pic_front.sv
// Front part: accepts transactions and registers them before queuing.
module pic_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pic_pkg::in_item_t in_data_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output pic_pkg::in_item_t q_data_o
);
  import pic_pkg::*;

  // one skid register parts the input from the queue
  logic     vld_q;
  in_item_t item_q;

  assign in_stall_o = vld_q && q_full_i;
  assign q_push_o   = vld_q && !q_full_i;
  assign q_data_o   = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) item_q <= in_data_i;
  end
endmodule

FILE: rtl/pic_back.sv
// Back part: register file, sequential priority scan and result register.
module pic_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  pic_pkg::in_item_t  q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pic_pkg::out_item_t out_data_o
);
  import pic_pkg::*;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StExec = 4'b0010,
    StScan = 4'b0100,
    StOut  = 4'b1000
  } state_e;

  // where the read data of a transaction comes from
  typedef enum logic [1:0] {
    SelPlain  = 2'd0,
    SelSource = 2'd1,
    SelPrio   = 2'd2
  } rsel_e;

  localparam int ScanW = $clog2(NumSources + 1);

  state_e state_q;
  logic [31:0] raw_q [NumBanks];
  logic [31:0] soft_q [NumBanks];
  logic [31:0] mask_q [NumBanks];
  logic [31:0] prio_mem [NumSources];
  logic [NumSources-1:0] pw_set_q;   // priority word written since reset
  logic [7:0]  thr_q;
  logic [31:0] syscfg_q, ctrl_q, prot_q, idle_q;

  in_item_t    it_q;
  logic [31:0] rd_q, rd_d;
  logic [1:0]  err_q, err_d;
  rsel_e       rsel_q, rsel_d;
  logic [ScanW-1:0] scan_q;
  logic        found_q;
  logic [SrcW-1:0] best_q;
  logic [5:0]  bestp_q;
  logic [31:0] pw_q;          // registered priority word read
  logic        pw_vld_q;
  out_item_t   out_q;
  logic        out_vld_q;

  // address decode
  logic        is_prio, is_bank;
  logic [9:0]  boff;
  logic [1:0]  bidx;
  logic [4:0]  slot;
  logic [6:0]  pidx;
  always_comb begin
    is_prio = (it_q.address >= PrioBase) &&
              (it_q.address < 10'(32'(PrioBase) + NumSources * 4));
    is_bank = (it_q.address >= BankBase) &&
              (it_q.address < 10'(32'(BankBase) + NumBanks * 32));
    boff    = it_q.address - BankBase;
    bidx    = boff[6:5];
    slot    = boff[4:0];
    pidx    = 7'((it_q.address - PrioBase) >> 2);
  end

  logic sv_ok;
  logic [1:0] sbank;
  assign sbank = it_q.source[6:5];
  assign sv_ok = (32'(it_q.source) < NumSources) && (32'(sbank) < NumBanks);

  // scan element
  logic [SrcW-1:0] sidx;
  logic [1:0]  sb;
  logic [4:0]  sbit;
  logic        spend;
  logic [SrcW-1:0] ridx;
  assign sidx  = scan_q[SrcW-1:0];
  assign sb    = sidx[6:5];
  assign sbit  = sidx[4:0];
  assign spend = (raw_q[sb][sbit] | soft_q[sb][sbit]) & ~mask_q[sb][sbit];

  // priority word address: the transaction's word while executing, else the scan
  assign ridx = (state_q == StExec) ? (it_q.action[1] ? it_q.source : pidx) : sidx;

  assign q_pop_o     = (state_q == StIdle) && !q_empty_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // read data and error of the transaction in execution
  always_comb begin
    rd_d   = '0;
    err_d  = ErrOk;
    rsel_d = SelPlain;
    case (it_q.action) inside
      ActRead, ActWrite: begin
        if (is_prio) begin
          if (it_q.action == ActRead) rd_d = pw_q;
        end else if (is_bank) begin
          unique case (slot) inside
            SlotRaw: if (it_q.action == ActRead) rd_d = raw_q[bidx];
            SlotMask, SlotMaskClr, SlotMaskSet:
              if (it_q.action == ActRead) rd_d = mask_q[bidx];
            SlotSoftSet, SlotSoftClr:
              if (it_q.action == ActRead) rd_d = soft_q[bidx];
            SlotPendIrq: if (it_q.action == ActRead)
              rd_d = (raw_q[bidx] | soft_q[bidx]) & ~mask_q[bidx];
            SlotPendFiq: ;
            default: err_d = ErrUnmapped;
          endcase
        end else begin
          unique case (it_q.address)
            RegRevision:   ;
            RegSysConfig:  if (it_q.action == ActRead) rd_d = syscfg_q;
            RegStatus:     if (it_q.action == ActRead) rd_d = 32'd1;
            RegIrqSource:  if (it_q.action == ActRead) rsel_d = SelSource;
            RegFiqSource:  if (it_q.action == ActRead) rd_d = SpuriousCode;
            RegControl:    if (it_q.action == ActRead) rd_d = ctrl_q;
            RegProtection: if (it_q.action == ActRead) rd_d = prot_q;
            RegIdle:       if (it_q.action == ActRead) rd_d = idle_q;
            RegIrqPrio:    if (it_q.action == ActRead) rsel_d = SelPrio;
            RegFiqPrio:    if (it_q.action == ActRead) rd_d = 32'(NoPrio);
            RegThreshold:  if (it_q.action == ActRead) rd_d = 32'(thr_q);
            default: err_d = ErrUnmapped;
          endcase
        end
      end
      default: begin
        if (!sv_ok) err_d = ErrRange;
        else if (it_q.action == ActRaise && pw_q[0]) err_d = ErrFiq;
      end
    endcase
  end

  // priority word memory, registered read; unwritten words read as zero
  always_ff @(posedge clk_i) begin
    if (state_q == StExec && it_q.action == ActWrite && is_prio)
      prio_mem[pidx] <= it_q.write_data;
    pw_q <= pw_set_q[ridx] ? prio_mem[ridx] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_set_q <= '0;
    end else if (state_q == StExec && it_q.action == ActWrite && is_prio) begin
      pw_set_q[pidx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) it_q <= q_data_i;
  end

  // control and register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      for (int b = 0; b < NumBanks; b++) begin
        raw_q[b] <= '0; soft_q[b] <= '0; mask_q[b] <= '1;
      end
      thr_q <= NoPrio; syscfg_q <= '0; ctrl_q <= '0; prot_q <= '0; idle_q <= '0;
      rd_q <= '0; err_q <= ErrOk; rsel_q <= SelPlain; scan_q <= '0; found_q <= 1'b0;
      best_q <= '0; bestp_q <= '0; pw_vld_q <= 1'b0; out_q <= '0; out_vld_q <= 1'b0;
    end else begin
      if (state_q != StOut && out_vld_q && !out_stall_i) out_vld_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (!q_empty_i) state_q <= StExec;
          pw_vld_q <= 1'b0;
        end
        StExec: begin
          // wait for the registered priority word of the source (raise check)
          if (!pw_vld_q) begin
            pw_vld_q <= 1'b1;
          end else begin
            rd_q   <= rd_d;
            err_q  <= err_d;
            rsel_q <= rsel_d;
            if (it_q.action == ActWrite) begin
              if (is_bank) begin
                case (slot)
                  SlotMask:    mask_q[bidx] <= it_q.write_data;
                  SlotMaskClr: mask_q[bidx] <= mask_q[bidx] & ~it_q.write_data;
                  SlotMaskSet: mask_q[bidx] <= mask_q[bidx] | it_q.write_data;
                  SlotSoftSet: soft_q[bidx] <= soft_q[bidx] | it_q.write_data;
                  SlotSoftClr: soft_q[bidx] <= soft_q[bidx] & ~it_q.write_data;
                  default: ;
                endcase
              end else if (!is_prio) begin
                case (it_q.address)
                  RegSysConfig:  syscfg_q <= it_q.write_data;
                  RegControl:    ctrl_q <= it_q.write_data;
                  RegProtection: prot_q <= it_q.write_data;
                  RegIdle:       idle_q <= it_q.write_data;
                  RegThreshold:  thr_q <= it_q.write_data[7:0];
                  default: ;
                endcase
              end
            end else if (it_q.action[1] && sv_ok) begin
              if (it_q.action == ActRaise) begin
                if (!pw_q[0]) raw_q[sbank][it_q.source[4:0]] <= 1'b1;
              end else raw_q[sbank][it_q.source[4:0]] <= 1'b0;
            end
            scan_q <= '0; found_q <= 1'b0; pw_vld_q <= 1'b0;
            state_q <= StScan;
          end
        end
        StScan: begin
          // each source in turn: address, then registered word
          if (!pw_vld_q) begin
            pw_vld_q <= 1'b1;
          end else begin
            pw_vld_q <= 1'b0;
            if (spend && ({2'b00, pw_q[7:2]} < thr_q) &&
                (!found_q || pw_q[7:2] < bestp_q)) begin
              found_q <= 1'b1; best_q <= sidx; bestp_q <= pw_q[7:2];
            end
            if (32'(scan_q) == NumSources - 1) state_q <= StOut;
            scan_q <= scan_q + ScanW'(1);
          end
        end
        StOut: begin
          if (!out_vld_q || !out_stall_i) begin
            out_vld_q <= 1'b1;
            out_q.error       <= err_q;
            out_q.irq_request <= found_q;
            if (err_q != ErrOk) out_q.read_data <= '0;
            else if (rsel_q == SelSource)
              out_q.read_data <= found_q ? 32'(best_q) : SpuriousCode;
            else if (rsel_q == SelPrio)
              out_q.read_data <= found_q ? 32'(bestp_q) : 32'(NoPrio);
            else out_q.read_data <= rd_q;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

FILE: tb/pic_checker.sv
// Transaction monitor, behavioral model and comparator for the interrupt controller.
`timescale 1ns / 100ps
module pic_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  pic_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  pic_pkg::out_item_t out_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import pic_pkg::*;

  // Shadow copy of the controller state
  logic [31:0] line_q [NumBanks];
  logic [31:0] soft_q [NumBanks];
  logic [31:0] mask_q [NumBanks];
  logic [31:0] prio_q [NumSources];
  logic [7:0]  thresh_q;
  logic [31:0] sysconf_q, ctrl_q, prot_q, idle_q;

  out_item_t result_fifo[$];

  assign pending_o = result_fifo.size();

  // Winning source of the arbitration, -1 when nothing is active
  function automatic int winning_source();
    int best;
    logic [5:0] best_prio, p;
    logic [31:0] pend;
    best = -1;
    best_prio = '1;
    for (int s = 0; s < NumSources; s++) begin
      pend = (line_q[s/BitsPerBank] | soft_q[s/BitsPerBank]) & ~mask_q[s/BitsPerBank];
      p = prio_q[s][7:2];
      if (pend[s%BitsPerBank] && {2'b00, p} < thresh_q && (best < 0 || p < best_prio)) begin
        best = s;
        best_prio = p;
      end
    end
    return best;
  endfunction

  // Register access; returns the error code and the read value
  function automatic error_e reg_access(input logic wr, input int off,
                                        input logic [31:0] val, output logic [31:0] rd);
    int idx, bank, slot, act;
    rd = '0;
    if (off >= int'(PrioBase) && off < int'(PrioBase) + NumSources * 4) begin
      idx = (off - int'(PrioBase)) / 4;
      if (wr) prio_q[idx] = val;
      else rd = prio_q[idx];
      return ErrOk;
    end
    if (off >= int'(BankBase) && off < int'(BankBase) + NumBanks * int'(BankStride)) begin
      bank = (off - int'(BankBase)) / int'(BankStride);
      slot = (off - int'(BankBase)) % int'(BankStride);
      case (slot)
        SlotRaw:     if (!wr) rd = line_q[bank];
        SlotMask:    if (wr) mask_q[bank] = val; else rd = mask_q[bank];
        SlotMaskClr: if (wr) mask_q[bank] &= ~val; else rd = mask_q[bank];
        SlotMaskSet: if (wr) mask_q[bank] |= val; else rd = mask_q[bank];
        SlotSoftSet: if (wr) soft_q[bank] |= val; else rd = soft_q[bank];
        SlotSoftClr: if (wr) soft_q[bank] &= ~val; else rd = soft_q[bank];
        SlotPendIrq: if (!wr) rd = (line_q[bank] | soft_q[bank]) & ~mask_q[bank];
        SlotPendFiq: ;
        default: return ErrUnmapped;
      endcase
      return ErrOk;
    end
    case (off)
      RegRevision: ;
      RegSysConfig: if (wr) sysconf_q = val; else rd = sysconf_q;
      RegStatus: if (!wr) rd = 32'd1;
      RegIrqSource: if (!wr) begin
        act = winning_source();
        rd = (act >= 0) ? 32'(act) : SpuriousCode;
      end
      RegFiqSource: if (!wr) rd = SpuriousCode;
      RegControl: if (wr) ctrl_q = val; else rd = ctrl_q;
      RegProtection: if (wr) prot_q = val; else rd = prot_q;
      RegIdle: if (wr) idle_q = val; else rd = idle_q;
      RegIrqPrio: if (!wr) begin
        act = winning_source();
        rd = (act >= 0) ? {26'd0, prio_q[act][7:2]} : {24'd0, NoPrio};
      end
      RegFiqPrio: if (!wr) rd = {24'd0, NoPrio};
      RegThreshold: if (wr) thresh_q = val[7:0]; else rd = {24'd0, thresh_q};
      default: return ErrUnmapped;
    endcase
    return ErrOk;
  endfunction

  // Apply one transaction to the shadow state and form its result
  function automatic out_item_t apply_item(input in_item_t it);
    out_item_t res;
    logic [31:0] rd;
    error_e err;
    int b;
    rd = '0;
    err = ErrOk;
    if (it.action == ActRead || it.action == ActWrite) begin
      err = reg_access(it.action == ActWrite, int'(it.address), it.write_data, rd);
      if (err != ErrOk) rd = '0;
    end else if (it.source >= NumSources) begin
      err = ErrRange;
    end else begin
      b = it.source / BitsPerBank;
      if (it.action == ActRaise) begin
        if (prio_q[it.source][0]) err = ErrFiq;
        else line_q[b][it.source % BitsPerBank] = 1'b1;
      end else begin
        line_q[b][it.source % BitsPerBank] = 1'b0;
      end
    end
    res.read_data = rd;
    res.irq_request = (winning_source() >= 0);
    res.error = err;
    return res;
  endfunction

  // Monitor both channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumBanks; i++) begin
        line_q[i] = '0;
        soft_q[i] = '0;
        mask_q[i] = '1;
      end
      for (int i = 0; i < NumSources; i++) prio_q[i] = '0;
      thresh_q = 8'hFF;
      sysconf_q = '0;
      ctrl_q = '0;
      prot_q = '0;
      idle_q = '0;
      result_fifo.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (result_fifo.size() == 0) begin
          $display("%0t: unexpected result expected none actual %h", $time, out_data_i);
          fail_count_o++;
        end else begin
          if (out_data_i.read_data !== result_fifo[0].read_data) begin
            $display("%0t: read_data expected %h actual %h", $time,
                     result_fifo[0].read_data, out_data_i.read_data);
            fail_count_o++;
          end
          if (out_data_i.irq_request !== result_fifo[0].irq_request) begin
            $display("%0t: irq_request expected %b actual %b", $time,
                     result_fifo[0].irq_request, out_data_i.irq_request);
            fail_count_o++;
          end
          if (out_data_i.error !== result_fifo[0].error) begin
            $display("%0t: error expected %0d actual %0d", $time,
                     result_fifo[0].error, out_data_i.error);
            fail_count_o++;
          end
          void'(result_fifo.pop_front());
        end
      end
      if (in_valid_i && !in_stall_i) result_fifo.push_back(apply_item(in_data_i));
    end
  end

endmodule

FILE: tb/tb_top.sv
// Stimulus, clocking and verdict for the interrupt controller testbench.
`timescale 1ns / 100ps
module tb_top;
  import pic_pkg::*;

  localparam int MaxCycles = 2_000_000;
  localparam int DrainCycles = 250;

  localparam logic [9:0] TopRegs [11] = '{RegRevision, RegSysConfig, RegStatus,
                                          RegIrqSource, RegFiqSource, RegControl,
                                          RegProtection, RegIdle, RegIrqPrio,
                                          RegFiqPrio, RegThreshold};

  logic      clk, rst_n;
  logic      in_valid, in_stall, out_valid, out_stall;
  in_item_t  in_data;
  out_item_t out_data;
  int        fail_count, pending, tx_idle_pct, rx_idle_pct, rx_hold, cycle_count;

  prioritized_interrupt_controller DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  pic_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Receiver stalls: random, plus a long hold when requested
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold <= rx_hold - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MaxCycles) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one transaction at the falling edge and wait for it to be taken
  task automatic send(input in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      in_data = '0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_sender();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    idle_sender();
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic in_item_t make_item(input action_e a, input logic [9:0] addr,
                                         input logic [31:0] d, input logic [6:0] s);
    in_item_t it;
    it.action = a;
    it.address = addr;
    it.write_data = d;
    it.source = s;
    return it;
  endfunction

  // Random offset, weighted toward the mapped registers
  function automatic logic [9:0] pick_offset();
    case ($urandom_range(9))
      0, 1, 2: return TopRegs[$urandom_range(10)];
      3, 4, 5: return BankBase + 10'($urandom_range(NumBanks - 1) * 32'(BankStride))
                      + 10'($urandom_range(7) * 4);
      6, 7: return PrioBase + 10'($urandom_range(NumSources - 1) * 4)
                   + (($urandom_range(5) == 0) ? 10'($urandom_range(3)) : 10'd0);
      default: return 10'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    logic [31:0] d;
    it.address = pick_offset();
    it.source = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(95));
    d = $urandom;
    // Priority words: mostly IRQ-routed and often within a narrow range to force ties
    if (it.address >= PrioBase && $urandom_range(7) != 0) begin
      d[0] = 1'b0;
      if ($urandom_range(1)) d[7:2] = 6'($urandom_range(7));
    end
    if (it.address == RegThreshold && $urandom_range(2) == 0) d[7:0] = 8'($urandom_range(12));
    it.write_data = d;
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5: it.action = ActRead;
      6, 7, 8, 9, 10, 11: it.action = ActWrite;
      12, 13, 14, 15, 16: it.action = ActRaise;
      default: it.action = ActDrop;
    endcase
    return it;
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    rx_hold = 0;
    cycle_count = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Load every priority word before anything can arbitrate
    for (int m = 0; m < NumSources; m++)
      send(make_item(ActWrite, PrioBase + 10'(m * 4), 32'(($urandom_range(15)) << 2), '0));

    // Directed: spurious reads, all-ones data, unmask, ties, FIQ, range, unaligned
    send(make_item(ActRead, RegIrqSource, '0, '0));
    send(make_item(ActRead, RegIrqPrio, '0, '0));
    send(make_item(ActRead, BankBase + 10'(SlotMask), '0, '0));
    send(make_item(ActWrite, RegControl, 32'hFFFF_FFFF, '0));
    send(make_item(ActRead, RegControl, '0, '0));
    send(make_item(ActWrite, PrioBase + 10'd20, 32'h0000_0008, '0));
    send(make_item(ActWrite, PrioBase + 10'd40, 32'h0000_0008, '0));
    send(make_item(ActWrite, BankBase + 10'(SlotMaskClr), 32'hFFFF_FFFF, '0));
    send(make_item(ActRaise, '0, '0, 7'd10));
    send(make_item(ActRaise, '0, '0, 7'd5));
    send(make_item(ActRead, RegIrqSource, '0, '0));
    send(make_item(ActRead, RegIrqPrio, '0, '0));
    send(make_item(ActWrite, RegThreshold, 32'h0000_0000, '0));
    send(make_item(ActRead, BankBase + 10'(SlotPendIrq), '0, '0));
    send(make_item(ActWrite, RegThreshold, 32'hFFFF_FFFF, '0));
    send(make_item(ActWrite, PrioBase + 10'd380, 32'h0000_0001, '0));
    send(make_item(ActRaise, '0, '0, 7'd95));
    send(make_item(ActRaise, '0, '0, 7'd96));
    send(make_item(ActDrop, '0, '0, 7'd127));
    send(make_item(ActDrop, '0, '0, 7'd10));
    send(make_item(ActRead, BankBase + 10'd2, '0, '0));
    send(make_item(ActWrite, PrioBase + 10'd3, 32'h0000_00FC, '0));
    send(make_item(ActRead, 10'h3FF, '0, '0));
    send(make_item(ActWrite, BankBase + BankStride + 10'(SlotSoftSet), 32'hFFFF_FFFF, '0));
    send(make_item(ActRead, RegIrqSource, '0, '0));
    wait_drained();

    // Random phases with different idle mixes
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 55 : 0;
      rx_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 28 : 0;
      if (ph == 2) begin
        // Long receiver hold while the sender keeps offering
        rx_hold = 1500;
        for (int i = 0; i < 8; i++) send(random_item());
      end
      for (int i = 0; i < 340; i++) send(random_item());
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
